>>> hdl/wsdf_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsdf_pkg;

  // Parser phase
  typedef enum logic [2:0] {
    PH_HEAD = 3'd0,
    PH_LEN  = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  // Class tag carried on each output word
  typedef enum logic [2:0] {
    CLS_HEAD = 3'd0,
    CLS_LEN  = 3'd1,
    CLS_EXT  = 3'd2,
    CLS_KEY  = 3'd3,
    CLS_DATA = 3'd4
  } byte_class_t;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 64;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned CLASS_W  = 3;
  localparam int unsigned OUT_W    = 80;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  // Extended length byte counts, minus one
  localparam logic [2:0] EXT_CNT_16 = 3'd1;
  localparam logic [2:0] EXT_CNT_64 = 3'd7;

endpackage

`default_nettype wire

>>> hdl/websocket_frame_deframer.sv
// WebSocket frame deframer top level: header walk, unmasking, output register.
`default_nettype none

// Parses an RFC 6455 frame stream one byte per word and emits one output word
// per input word, tagged with its class (header, length, extended length,
// mask key, payload), the unmasked data and the current frame's header fields.
// Throughput is one byte per clock when out_tready does not stall it; output
// valid follows input accept in the next cycle, set by the single output
// register. The input is ready whenever the output register is empty or
// being drained in the same cycle. tlast marks the last byte of each frame,
// including the last header byte of a zero-length frame.
module websocket_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] stream_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,  // [7:0] out_data, [8] final_fragment,
                                       // [12:9] frame_opcode, [13] is_masked,
                                       // [77:14] frame_length, [79:78] zero
  output logic [2:0]       out_tuser,  // [2:0] byte_class
  output logic             out_tlast   // frame_end
);

  wsdf_pkg::phase_t                     phase_r, phase_nxt;
  logic [2:0]                           field_cnt_r, field_cnt_nxt;
  logic                                 fin_r, fin_nxt;
  logic [wsdf_pkg::OPCODE_W-1:0]        opcode_r, opcode_nxt;
  logic                                 mask_flag_r, mask_flag_nxt;
  logic [wsdf_pkg::LEN_W-1:0]           length_r, length_nxt;
  logic [wsdf_pkg::LEN_W-1:0]           remaining_r, remaining_nxt;
  logic [wsdf_pkg::KEY_W-1:0]           mask_key_r, mask_key_nxt;
  logic [1:0]                           key_phase_r, key_phase_nxt;

  logic                                 out_valid_r;
  logic [wsdf_pkg::OUT_W-1:0]           out_data_r, out_data_nxt;
  logic [wsdf_pkg::CLASS_W-1:0]         out_class_r;
  logic                                 out_last_r;

  wsdf_pkg::byte_class_t                cls;
  logic [wsdf_pkg::BYTE_W-1:0]          data;
  logic [wsdf_pkg::BYTE_W-1:0]          key_byte;
  logic                                 frame_end;
  logic                                 len_done;
  logic                                 hdr_done;
  logic [wsdf_pkg::LEN_W-1:0]           rem_dec;
  logic                                 in_acc;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign rem_dec   = remaining_r - wsdf_pkg::LEN_W'(1);

  always_comb begin
    case (key_phase_r)
      2'd0:    key_byte = mask_key_r[31:24];
      2'd1:    key_byte = mask_key_r[23:16];
      2'd2:    key_byte = mask_key_r[15:8];
      default: key_byte = mask_key_r[7:0];
    endcase
  end

  always_comb begin
    phase_nxt     = phase_r;
    field_cnt_nxt = field_cnt_r;
    fin_nxt       = fin_r;
    opcode_nxt    = opcode_r;
    mask_flag_nxt = mask_flag_r;
    length_nxt    = length_r;
    remaining_nxt = remaining_r;
    mask_key_nxt  = mask_key_r;
    key_phase_nxt = key_phase_r;
    cls           = wsdf_pkg::CLS_HEAD;
    data          = in_tdata;
    frame_end     = 1'b0;
    len_done      = 1'b0;
    hdr_done      = 1'b0;

    case (phase_r)
      wsdf_pkg::PH_LEN: begin
        cls           = wsdf_pkg::CLS_LEN;
        mask_flag_nxt = in_tdata[7];
        if (in_tdata[6:0] == wsdf_pkg::LEN_CODE_16) begin
          length_nxt    = '0;
          field_cnt_nxt = wsdf_pkg::EXT_CNT_16;
          phase_nxt     = wsdf_pkg::PH_EXT;
        end else if (in_tdata[6:0] == wsdf_pkg::LEN_CODE_64) begin
          length_nxt    = '0;
          field_cnt_nxt = wsdf_pkg::EXT_CNT_64;
          phase_nxt     = wsdf_pkg::PH_EXT;
        end else begin
          length_nxt = {57'd0, in_tdata[6:0]};
          len_done   = 1'b1;
        end
      end
      wsdf_pkg::PH_EXT: begin
        cls        = wsdf_pkg::CLS_EXT;
        length_nxt = {length_r[wsdf_pkg::LEN_W-9:0], in_tdata};
        if (field_cnt_r == 3'd0) begin
          len_done = 1'b1;
        end else begin
          field_cnt_nxt = field_cnt_r - 3'd1;
        end
      end
      wsdf_pkg::PH_KEY: begin
        cls          = wsdf_pkg::CLS_KEY;
        mask_key_nxt = {mask_key_r[wsdf_pkg::KEY_W-9:0], in_tdata};
        if (key_phase_r == 2'd3) begin
          hdr_done = 1'b1;
        end else begin
          key_phase_nxt = key_phase_r + 2'd1;
        end
      end
      wsdf_pkg::PH_DATA: begin
        cls = wsdf_pkg::CLS_DATA;
        if (mask_flag_r) begin
          data = in_tdata ^ key_byte;
        end
        key_phase_nxt = key_phase_r + 2'd1;
        remaining_nxt = rem_dec;
        if (rem_dec == '0) begin
          frame_end = 1'b1;
          phase_nxt = wsdf_pkg::PH_HEAD;
        end
      end
      default: begin
        cls           = wsdf_pkg::CLS_HEAD;
        fin_nxt       = in_tdata[7];
        opcode_nxt    = in_tdata[3:0];
        mask_flag_nxt = 1'b0;
        length_nxt    = '0;
        remaining_nxt = '0;
        field_cnt_nxt = 3'd0;
        key_phase_nxt = 2'd0;
        phase_nxt     = wsdf_pkg::PH_LEN;
      end
    endcase

    // Length complete: collect the key, or the header is done
    if (len_done) begin
      if (mask_flag_nxt) begin
        phase_nxt     = wsdf_pkg::PH_KEY;
        key_phase_nxt = 2'd0;
        mask_key_nxt  = '0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: zero-length frames end here
    if (hdr_done) begin
      key_phase_nxt = 2'd0;
      if (length_nxt == '0) begin
        phase_nxt     = wsdf_pkg::PH_HEAD;
        remaining_nxt = '0;
        frame_end     = 1'b1;
      end else begin
        remaining_nxt = length_nxt;
        phase_nxt     = wsdf_pkg::PH_DATA;
      end
    end

    out_data_nxt = {2'b00, length_nxt, mask_flag_nxt, opcode_nxt, fin_nxt, data};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= wsdf_pkg::PH_HEAD;
      field_cnt_r <= '0;
      fin_r       <= 1'b0;
      opcode_r    <= '0;
      mask_flag_r <= 1'b0;
      length_r    <= '0;
      remaining_r <= '0;
      mask_key_r  <= '0;
      key_phase_r <= '0;
    end else if (in_acc) begin
      phase_r     <= phase_nxt;
      field_cnt_r <= field_cnt_nxt;
      fin_r       <= fin_nxt;
      opcode_r    <= opcode_nxt;
      mask_flag_r <= mask_flag_nxt;
      length_r    <= length_nxt;
      remaining_r <= remaining_nxt;
      mask_key_r  <= mask_key_nxt;
      key_phase_r <= key_phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r  <= out_data_nxt;
      out_class_r <= cls;
      out_last_r  <= frame_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_class_r;
  assign out_tlast  = out_last_r;

  // A first header byte never ends a frame
  a_head_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_class_r == wsdf_pkg::CLS_HEAD) |-> !out_last_r)
    else $error("frame end flagged on first header byte");

  // Payload phase always has bytes left to take
  a_data_remaining: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == wsdf_pkg::PH_DATA) |-> (remaining_r != '0))
    else $error("payload phase with zero bytes remaining");

  // A first header byte always moves on to the length byte
  a_head_to_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == wsdf_pkg::PH_HEAD) |=> (phase_r == wsdf_pkg::PH_LEN))
    else $error("first header byte not followed by length phase");

  // Payload words carry the class of the phase they came from
  a_data_class: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && phase_r == wsdf_pkg::PH_DATA) |=>
      (out_valid_r && out_class_r == wsdf_pkg::CLS_DATA))
    else $error("payload byte emitted with wrong class");

endmodule

`default_nettype wire

>>> tb/wsdf_tb_pkg.sv
// Scoreboard for the WebSocket frame deframer: header walk predictor and word checker.
package wsdf_tb_pkg;
  import wsdf_pkg::*;

  typedef struct {
    byte_class_t  cls;
    logic [7:0]   data;
    logic         fin;
    logic [3:0]   opcode;
    logic         masked;
    logic [63:0]  length;
    logic         last;
  } deframe_word_t;

  class deframe_checker;
    deframe_word_t pending_words[$];
    int            mismatches;

    phase_t        phase;
    logic [2:0]    ext_left;
    logic          fin;
    logic [3:0]    opcode;
    logic          masked;
    logic [63:0]   length;
    logic [63:0]   remaining;
    logic [31:0]   mask_key;
    logic [1:0]    key_idx;

    function new();
      mismatches = 0;
      phase      = PH_HEAD;
      ext_left   = '0;
      fin        = 1'b0;
      opcode     = '0;
      masked     = 1'b0;
      length     = '0;
      remaining  = '0;
      mask_key   = '0;
      key_idx    = '0;
    endfunction

    function int pending();
      return pending_words.size();
    endfunction

    // Length and key known: start the payload, or close an empty frame.
    function logic finish_header();
      key_idx = '0;
      if (length == 0) begin
        phase     = PH_HEAD;
        remaining = '0;
        return 1'b1;
      end
      remaining = length;
      phase     = PH_DATA;
      return 1'b0;
    endfunction

    function logic finish_length();
      if (masked) begin
        phase    = PH_KEY;
        key_idx  = '0;
        mask_key = '0;
        return 1'b0;
      end
      return finish_header();
    endfunction

    // Predict the word caused by one accepted stream byte.
    function void take_byte(logic [7:0] b);
      deframe_word_t w;
      logic [6:0]    code;
      w.data = b;
      w.last = 1'b0;
      case (phase)
        PH_LEN: begin
          w.cls  = CLS_LEN;
          code   = b[6:0];
          masked = b[7];
          if (code == LEN_CODE_16) begin
            length   = '0;
            ext_left = EXT_CNT_16;
            phase    = PH_EXT;
          end else if (code == LEN_CODE_64) begin
            length   = '0;
            ext_left = EXT_CNT_64;
            phase    = PH_EXT;
          end else begin
            length = 64'(code);
            w.last = finish_length();
          end
        end
        PH_EXT: begin
          w.cls  = CLS_EXT;
          length = {length[55:0], b};
          if (ext_left == 0) w.last = finish_length();
          else ext_left = ext_left - 3'd1;
        end
        PH_KEY: begin
          w.cls    = CLS_KEY;
          mask_key = {mask_key[23:0], b};
          if (key_idx == 2'd3) w.last = finish_header();
          else key_idx = key_idx + 2'd1;
        end
        PH_DATA: begin
          w.cls = CLS_DATA;
          // first key byte sits in the top bits
          if (masked) w.data = b ^ 8'(mask_key >> (24 - 8 * key_idx));
          key_idx   = key_idx + 2'd1;
          remaining = remaining - 64'd1;
          if (remaining == 0) begin
            w.last = 1'b1;
            phase  = PH_HEAD;
          end
        end
        default: begin
          w.cls     = CLS_HEAD;
          fin       = b[7];
          opcode    = b[3:0];
          masked    = 1'b0;
          length    = '0;
          remaining = '0;
          ext_left  = '0;
          key_idx   = '0;
          phase     = PH_LEN;
        end
      endcase
      w.fin    = fin;
      w.opcode = opcode;
      w.masked = masked;
      w.length = length;
      pending_words.insert(pending_words.size(), w);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(logic [79:0] tdata, logic [2:0] tuser, logic tlast);
      deframe_word_t w;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, got tdata %0h tuser %0h",
                 $time, tdata, tuser);
        mismatches++;
        return;
      end
      w = pending_words.pop_front();
      compare_field("byte_class", 64'(w.cls), 64'(tuser));
      compare_field("out_data", 64'(w.data), 64'(tdata[7:0]));
      compare_field("final_fragment", 64'(w.fin), 64'(tdata[8]));
      compare_field("frame_opcode", 64'(w.opcode), 64'(tdata[12:9]));
      compare_field("is_masked", 64'(w.masked), 64'(tdata[13]));
      compare_field("frame_length", w.length, tdata[77:14]);
      compare_field("frame_end", 64'(w.last), 64'(tlast));
    endfunction
  endclass

endpackage

>>> tb/tb_top.sv
// Top-level testbench for the WebSocket frame deframer.
module tb_top;
  import wsdf_pkg::*;
  import wsdf_tb_pkg::*;

  typedef enum int {ENC_SHORT, ENC_16, ENC_64} len_enc_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  deframe_checker sb;
  bit             steady_phase = 1'b0;
  int             accepted_bytes = 0;

  websocket_frame_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sb.take_byte(b);
    accepted_bytes++;
  endtask

  task automatic drive_frame(input logic [7:0] head, input logic mask, input len_enc_t enc,
                             input logic [63:0] len, input logic [31:0] key, input int npay);
    int nbytes;
    send_byte(head);
    case (enc)
      ENC_16:  send_byte({mask, LEN_CODE_16});
      ENC_64:  send_byte({mask, LEN_CODE_64});
      default: send_byte({mask, len[6:0]});
    endcase
    nbytes = (enc == ENC_16) ? 2 : (enc == ENC_64) ? 8 : 0;
    for (int i = nbytes - 1; i >= 0; i--) send_byte(len[8*i +: 8]);
    if (mask)
      for (int i = 0; i < 4; i++) send_byte(8'(key >> (24 - 8 * i)));
    repeat (npay) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic random_frame();
    logic [7:0]  head;
    logic        mask;
    logic [31:0] key;
    logic [63:0] len;
    len_enc_t    enc;
    int          r;
    steady_phase = ($urandom_range(0, 5) == 0);
    head = 8'($urandom_range(0, 255));
    mask = 1'($urandom_range(0, 1));
    key  = $urandom;
    r    = $urandom_range(0, 99);
    if (r < 55) begin
      enc = ENC_SHORT;
      len = 64'($urandom_range(0, 8));
    end else if (r < 70) begin
      enc = ENC_SHORT;
      len = 64'($urandom_range(9, 125));
    end else if (r < 85) begin
      enc = ENC_16;
      len = ($urandom_range(0, 7) == 0) ? 64'($urandom_range(126, 300))
                                        : 64'($urandom_range(0, 12));
    end else begin
      enc = ENC_64;
      len = 64'($urandom_range(0, 12));
    end
    drive_frame(head, mask, enc, len, key, int'(len));
  endtask

  // result side: random back-pressure, check every accepted word
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tuser, out_tlast);
      if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        stall = pick_gap();
        out_tready <= (stall == 0);
      end
    end
  end

  initial begin
    logic [63:0] huge_len;
    sb = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    steady_phase = 1'b1;
    drive_frame(8'h00, 1'b0, ENC_SHORT, 64'd0, 32'h0, 0);          // empty, unmasked
    drive_frame(8'hFF, 1'b1, ENC_SHORT, 64'd0, 32'hFF00_A55A, 0);  // empty, ends on key
    steady_phase = 1'b0;
    drive_frame(8'h81, 1'b1, ENC_SHORT, 64'd2, 32'h1234_89AB, 2);
    drive_frame(8'h7A, 1'b0, ENC_16, 64'd1, 32'h0, 1);
    drive_frame(8'h09, 1'b0, ENC_16, 64'd0, 32'h0, 0);             // empty, ends on ext length

    while (accepted_bytes < 400) random_frame();

    // 64-bit length with its top bit set: only a few payload bytes follow
    huge_len = {1'b1, 31'($urandom), 32'($urandom)};
    drive_frame(8'h82, 1'($urandom_range(0, 1)), ENC_64, huge_len, $urandom, 12);
    in_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("websocket_frame_deframer test passed");
    end else begin
      $display("websocket_frame_deframer test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("websocket_frame_deframer test failed");
    $finish;
  end

endmodule

>>> websocket_frame_deframer.f
hdl/wsdf_pkg.sv
hdl/websocket_frame_deframer.sv
tb/wsdf_tb_pkg.sv
tb/tb_top.sv
